[hw/rtl/kwm_pkg.sv]
// Shared widths, codes and types of the k-way sorted merge.
`default_nettype none
package kwm_pkg;

    localparam int KIND_W        = 1;
    localparam int LANE_W        = 3;
    localparam int VALUE_W       = 32;
    localparam int CFG_W         = 4;
    localparam int IDX_MAX_W     = 6;
    localparam int DEF_MAX_LANES = 8;

    localparam logic [CFG_W-1:0]  LANES_RESET = 4'd8;

    localparam logic [KIND_W-1:0] KIND_VALUE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_END   = 1'b1;
    localparam logic [KIND_W-1:0] RES_ELEM   = 1'b0;
    localparam logic [KIND_W-1:0] RES_DONE   = 1'b1;

    // outcome of one minimum scan over the head memory
    typedef struct packed {
        logic                        found;
        logic [IDX_MAX_W-1:0]        idx;
        logic signed [VALUE_W-1:0]   val;
    } scan_res_t;

endpackage
`default_nettype wire

[hw/rtl/kwm_head_mem.sv]
// Head value memory: one write port, one read port, registered read data.
`default_nettype none
module kwm_head_mem
    import kwm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_LANES,
    parameter int AW    = $clog2(DEF_MAX_LANES)
)
(
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic signed [VALUE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic signed [VALUE_W-1:0]      rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/kwm_scan.sv]
// Minimum scan: walks the head memory one lane per cycle, keeps lowest valid head.
`default_nettype none
module kwm_scan
    import kwm_pkg::*;
#(
    parameter int MAX_LANES = DEF_MAX_LANES,
    parameter int LW        = $clog2(DEF_MAX_LANES),
    parameter int CW        = $clog2(DEF_MAX_LANES + 1),
    parameter int NW        = CFG_W
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [NW-1:0]             n,
    input  wire logic [MAX_LANES-1:0]      head_valid,
    output logic                           rd_en,
    output logic [LW-1:0]                  rd_addr,
    input  wire logic signed [VALUE_W-1:0] rd_data,
    output logic                           done,
    output scan_res_t                      res
);

    logic                      busy_reg;
    logic [CW-1:0]             idx_reg;
    logic                      pend_reg;
    logic [LW-1:0]             pend_idx_reg;
    logic                      have_reg;
    logic [LW-1:0]             best_idx_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic                      more;
    logic                      take;

    assign more    = NW'(idx_reg) < n;
    assign rd_en   = busy_reg && more;
    assign rd_addr = idx_reg[LW-1:0];
    assign done    = busy_reg && !more && !pend_reg;

    // strict less keeps the lowest lane on ties
    assign take = pend_reg && head_valid[pend_idx_reg]
                  && (!have_reg || (rd_data < best_val_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (more)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            pend_reg <= more;
            if (take)
            begin
                have_reg <= 1'b1;
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            pend_idx_reg <= idx_reg[LW-1:0];
            if (take)
            begin
                best_idx_reg <= pend_idx_reg;
                best_val_reg <= rd_data;
            end
        end
    end

    assign res.found = have_reg;
    assign res.idx   = IDX_MAX_W'(best_idx_reg);
    assign res.val   = best_val_reg;

endmodule
`default_nettype wire

[hw/rtl/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge: lane flags, sequencer and output register.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------
//  in      | in  | in_valid / in_stall  | kind, lane, value
//  out     | out | out_valid / out_stall| kind_res, value_res, lane_res
//  cfg     | in  | cfg_valid / cfg_ready| lanes_in_use
//
// A request that leaves some active lane without head or end goes through the
// check state back to idle. One that completes the set with a head left goes
// through check, scan and emit, the scan reading the head memory one entry per
// cycle through its read port; one that ends the last open lane emits the finish.
// Reset clears the lane flags at once; the head memory is never cleared.
// The next request is taken while a result waits in the output register;
// a new result waits for the output register to free up.
`default_nettype none
module k_way_sorted_merge
    import kwm_pkg::*;
#(
    parameter int MAX_LANES = DEF_MAX_LANES
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [KIND_W-1:0]         kind,
    input  wire logic [LANE_W-1:0]         lane,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [KIND_W-1:0]              kind_res,
    output logic signed [VALUE_W-1:0]      value_res,
    output logic [LANE_W-1:0]              lane_res,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_W-1:0]          lanes_in_use
);

    localparam int LW = $clog2(MAX_LANES);
    localparam int CW = $clog2(MAX_LANES + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          lanes_reg;
    logic [MAX_LANES-1:0]      valid_reg, valid_next;
    logic [MAX_LANES-1:0]      ended_reg, ended_next;
    logic                      finish_reg, finish_next;
    logic                      out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]         kind_res_reg, kind_res_next;
    logic signed [VALUE_W-1:0] value_res_reg, value_res_next;
    logic [LANE_W-1:0]         lane_res_reg, lane_res_next;

    logic [NW-1:0]             n;
    logic [NW-1:0]             lanes_ext;
    logic [MAX_LANES-1:0]      act_mask;
    logic [LW-1:0]             lane_idx;
    logic                      accept;
    logic                      lane_open;
    logic                      all_ready;
    logic                      any_head;
    logic                      slot_free;
    logic                      scan_start;
    logic                      scan_done;
    logic                      rd_en;
    logic [LW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    scan_res_t                 scan_res;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    // active lane count, clamped to 1..MAX_LANES
    assign lanes_ext = NW'(lanes_reg);
    always_comb
    begin
        if (lanes_ext == '0)
        begin
            n = NW'(1);
        end
        else if (lanes_ext > NW'(MAX_LANES))
        begin
            n = NW'(MAX_LANES);
        end
        else
        begin
            n = lanes_ext;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LANES; i++)
        begin
            act_mask[i] = NW'(i) < n;
        end
    end

    assign lane_idx  = LW'(lane);
    assign lane_open = (NW'(lane) < n) && !valid_reg[lane_idx] && !ended_reg[lane_idx];
    assign all_ready = &(valid_reg | ended_reg | ~act_mask);
    assign any_head  = |(valid_reg & act_mask);
    assign slot_free = !out_valid_reg || !out_stall;
    assign scan_start = (state_reg == ST_CHECK) && all_ready && any_head;

    kwm_head_mem #(
        .DEPTH (MAX_LANES),
        .AW    (LW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept && lane_open && (kind == KIND_VALUE)),
        .wr_addr (lane_idx),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kwm_scan #(
        .MAX_LANES (MAX_LANES),
        .LW        (LW),
        .CW        (CW),
        .NW        (NW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .n          (n),
        .head_valid (valid_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .done       (scan_done),
        .res        (scan_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        ended_next     = ended_reg;
        finish_next    = finish_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_res_next  = kind_res_reg;
        value_res_next = value_res_reg;
        lane_res_next  = lane_res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (lane_open)
                    begin
                        if (kind == KIND_VALUE)
                        begin
                            valid_next[lane_idx] = 1'b1;
                        end
                        else
                        begin
                            ended_next[lane_idx] = 1'b1;
                        end
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!all_ready)
                begin
                    state_next = ST_IDLE;
                end
                else if (any_head)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    finish_next = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    finish_next = 1'b0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (finish_reg)
                    begin
                        kind_res_next  = RES_DONE;
                        value_res_next = '0;
                        lane_res_next  = '0;
                        valid_next     = '0;
                        ended_next     = '0;
                    end
                    else
                    begin
                        kind_res_next  = RES_ELEM;
                        value_res_next = scan_res.val;
                        lane_res_next  = LANE_W'(scan_res.idx);
                        valid_next[LW'(scan_res.idx)] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lanes_reg     <= LANES_RESET;
            valid_reg     <= '0;
            ended_reg     <= '0;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_res_reg  <= RES_ELEM;
            value_res_reg <= '0;
            lane_res_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            ended_reg     <= ended_next;
            finish_reg    <= finish_next;
            out_valid_reg <= out_valid_next;
            kind_res_reg  <= kind_res_next;
            value_res_reg <= value_res_next;
            lane_res_reg  <= lane_res_next;
            if (cfg_valid && cfg_ready)
            begin
                lanes_reg <= lanes_in_use;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind_res  = kind_res_reg;
    assign value_res = value_res_reg;
    assign lane_res  = lane_res_reg;

endmodule
`default_nettype wire
